/* rtl/spq_pkg.sv */
// shared constants and request codes for the sorted priority queue
package spq_pkg;

	localparam int DEPTH   = 64;
	localparam int KEY_W   = 16;
	localparam int DATA_W  = 32;
	localparam int ENTRY_W = KEY_W + DATA_W;
	localparam int COUNT_W = 7;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = $clog2(2 * DEPTH);

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;

endpackage

/* rtl/spq_if.sv */
// request and result channel interfaces of the sorted priority queue
interface spq_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  req_type;
	logic [spq_pkg::KEY_W-1:0]   entry_key;
	logic [spq_pkg::DATA_W-1:0]  entry_payload;

	modport source (output valid, output req_type, output entry_key, output entry_payload,
		input ready);
	modport sink (input valid, input req_type, input entry_key, input entry_payload,
		output ready);
endinterface

interface spq_res_if;
	logic                          valid;
	logic                          ready;
	logic                          out_valid;
	logic [spq_pkg::KEY_W-1:0]     out_key;
	logic [spq_pkg::DATA_W-1:0]    out_payload;
	logic                          insert_ok;
	logic [spq_pkg::COUNT_W-1:0]   entry_count;

	modport source (output valid, output out_valid, output out_key, output out_payload,
		output insert_ok, output entry_count, input ready);
	modport sink (input valid, input out_valid, input out_key, input out_payload,
		input insert_ok, input entry_count, output ready);
endinterface

/* rtl/sorted_priority_queue.sv */
// sorted priority queue: entries kept in key order in a circular ram
// req channel: one request per transaction, insert (key and payload),
//   pop of the smallest entry, or flush of all entries
// res channel: exactly one result transaction per request, the popped
//   entry (out_valid, out_key, out_payload), insert_ok and the entry
//   count after the request
// one request is worked on at a time; req.ready is high only while the
//   sequencer is idle; one key comparator is reused every cycle of the search,
//   and one ram port pair serves both the search and the shift
// steps from request accept to result valid, with n entries held
//   flush, unused code, pop on empty, insert into a full queue: straight to done
//   pop, insert into an empty queue: the pop or the write, then done
//   other inserts: compare with the head, then with the tail; in front of
//   the head all n words shift, behind the tail the write follows; in the
//   middle a forward scan finds p, then n - p words shift, each read then written
// req.ready returns with the result, so a new request is not taken before it is valid
// reset clears the count, head pointer, sequencer and result valid;
//   ram contents are not cleared and only words below the count are used
// a stalled receiver holds the result register; the next request may be
//   accepted meanwhile and then waits in the done state until it drains
module sorted_priority_queue (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_res_if.source  res
);

	localparam int AW = spq_pkg::ADDR_W;
	localparam int CW = spq_pkg::CNT_W;
	localparam int SW = spq_pkg::SUM_W;
	localparam int KW = spq_pkg::KEY_W;
	localparam int DW = spq_pkg::DATA_W;

	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_TAIL  = 4'd1;
	localparam logic [3:0] ST_HEAD  = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_SH_RD = 4'd4;
	localparam logic [3:0] ST_SH_WR = 4'd5;
	localparam logic [3:0] ST_INS   = 4'd6;
	localparam logic [3:0] ST_POP   = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]    state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic          res_valid_q;

	// request fields held for the whole transaction
	logic [KW-1:0] key_q;
	logic [DW-1:0] pay_q;

	// result being built, then the output register
	logic          pend_hit_q;
	logic          pend_ok_q;
	logic [KW-1:0] pend_key_q;
	logic [DW-1:0] pend_pay_q;
	logic          out_hit_q;
	logic          out_ok_q;
	logic [KW-1:0] out_key_q;
	logic [DW-1:0] out_pay_q;
	logic [spq_pkg::COUNT_W-1:0] out_cnt_q;

	// ram and shared comparator
	logic                       we;
	logic [CW-1:0]              rd_idx;
	logic [CW-1:0]              wr_idx;
	logic [spq_pkg::ENTRY_W-1:0] wdata;
	logic [spq_pkg::ENTRY_W-1:0] rdata;
	logic [KW-1:0]              rd_key;
	logic [DW-1:0]              rd_pay;
	logic [KW-1:0]              cmp_a;
	logic [KW-1:0]              cmp_b;
	logic                       ge;
	logic                       req_fire;
	logic                       out_free;
	logic [AW-1:0]              head_next;

	// logical position to ram address, wrapping around the ring
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] idx);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(idx);
		if (sum >= SW'(spq_pkg::DEPTH)) begin
			sum = sum - SW'(spq_pkg::DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign rd_key = rdata[DW +: KW];
	assign rd_pay = rdata[DW-1:0];
	assign ge     = cmp_a >= cmp_b;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !res_valid_q || res.ready;
	assign head_next = (head_q == AW'(spq_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;

	// address and operand selection per state
	always_comb begin
		rd_idx = '0;
		we     = 1'b0;
		wr_idx = pos_q;
		wdata  = {key_q, pay_q};
		cmp_a  = key_q;
		cmp_b  = rd_key;
		unique case (state_q)
			ST_IDLE: begin
				// pop and insert both read the head
				rd_idx = '0;
			end
			ST_HEAD: begin
				// tail read for the next compare
				rd_idx = count_q - 1'b1;
				cmp_a  = rd_key;
				cmp_b  = key_q;
			end
			ST_TAIL: begin
				rd_idx = CW'(1);
			end
			ST_SCAN: begin
				rd_idx = idx_q + 1'b1;
				cmp_a  = rd_key;
				cmp_b  = key_q;
			end
			ST_SH_RD: begin
				rd_idx = idx_q - 1'b1;
			end
			ST_SH_WR: begin
				we     = 1'b1;
				wr_idx = idx_q;
				wdata  = rdata;
			end
			ST_INS: begin
				we = 1'b1;
			end
			default: ;
		endcase
	end

	spq_ram #(
		.WIDTH(spq_pkg::ENTRY_W),
		.WORDS(spq_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(phys(head_q, wr_idx)),
		.wdata(wdata),
		.raddr(phys(head_q, rd_idx)),
		.rdata(rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// result register: load from done, clear once taken
			if (state_q == ST_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.req_type)
							spq_pkg::REQ_INSERT: begin
								if (count_q == CW'(spq_pkg::DEPTH)) begin
									state_q <= ST_DONE;
								end else if (count_q == '0) begin
									pos_q   <= '0;
									state_q <= ST_INS;
								end else begin
									state_q <= ST_HEAD;
								end
							end
							spq_pkg::REQ_POP: begin
								state_q <= (count_q == '0) ? ST_DONE : ST_POP;
							end
							spq_pkg::REQ_FLUSH: begin
								count_q <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_HEAD: begin
					// key not above the head: goes in front
					if (ge) begin
						pos_q   <= '0;
						idx_q   <= count_q;
						state_q <= ST_SH_RD;
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					// key not below the tail: append
					if (ge) begin
						pos_q   <= count_q;
						state_q <= ST_INS;
					end else begin
						idx_q   <= CW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// first stored key not below the new key
					if (ge) begin
						pos_q   <= idx_q;
						idx_q   <= count_q;
						state_q <= ST_SH_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SH_RD: begin
					state_q <= ST_SH_WR;
				end
				ST_SH_WR: begin
					idx_q   <= idx_q - 1'b1;
					state_q <= (idx_q - 1'b1 == pos_q) ? ST_INS : ST_SH_RD;
				end
				ST_INS: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_POP: begin
					head_q  <= head_next;
					count_q <= count_q - 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (req_fire) begin
			key_q      <= req.entry_key;
			pay_q      <= req.entry_payload;
			pend_hit_q <= 1'b0;
			pend_ok_q  <= 1'b0;
			pend_key_q <= '0;
			pend_pay_q <= '0;
		end
		if (state_q == ST_INS) begin
			pend_ok_q <= 1'b1;
		end
		if (state_q == ST_POP) begin
			pend_hit_q <= 1'b1;
			pend_key_q <= rd_key;
			pend_pay_q <= rd_pay;
		end
		if (state_q == ST_DONE && out_free) begin
			out_hit_q <= pend_hit_q;
			out_ok_q  <= pend_ok_q;
			out_key_q <= pend_key_q;
			out_pay_q <= pend_pay_q;
			out_cnt_q <= spq_pkg::COUNT_W'(count_q);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.out_valid   = out_hit_q;
	assign res.out_key     = out_key_q;
	assign res.out_payload = out_pay_q;
	assign res.insert_ok   = out_ok_q;
	assign res.entry_count = out_cnt_q;

endmodule

/* rtl/spq_ram.sv */
// generic single write, single registered read port ram
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int WORDS = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(WORDS)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(WORDS)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/spq_checker.sv */
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          out_valid,
	input logic [spq_pkg::KEY_W-1:0]     out_key,
	input logic [spq_pkg::DATA_W-1:0]    out_payload,
	input logic                          insert_ok,
	input logic [spq_pkg::COUNT_W-1:0]   entry_count
);

	// count never beyond capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> entry_count <= spq_pkg::COUNT_W'(spq_pkg::DEPTH))
		else $error("entry count above capacity");

	// a result without a pop hit carries zero key and payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> (out_key == '0 && out_payload == '0))
		else $error("nonzero fields on empty result");

	// a result is either a pop hit or an insert ack, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(out_valid && insert_ok))
		else $error("pop hit and insert ack together");

	// stalled result holds its fields
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(out_valid) && $stable(out_key)
			&& $stable(out_payload) && $stable(insert_ok) && $stable(entry_count)))
		else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.out_valid  (res.out_valid),
	.out_key    (res.out_key),
	.out_payload(res.out_payload),
	.insert_ok  (res.insert_ok),
	.entry_count(res.entry_count)
);

/* tb/sorted_priority_queue_tb.sv */
// self-checking testbench for the sorted priority queue: directed, fill, stall and random requests
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

	localparam int KEY_W   = spq_pkg::KEY_W;
	localparam int DATA_W  = spq_pkg::DATA_W;
	localparam int COUNT_W = spq_pkg::COUNT_W;
	localparam int DEPTH   = spq_pkg::DEPTH;

	// request code the block has no use for; it must only report the count
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int MAX_GAP       = 14;
	localparam int HOLD_OFF      = 300;   // long receiver stall for the pressure test
	localparam int DRAIN_LIMIT   = 2000;  // cycles to wait for outstanding results
	localparam int SETTLE_CYCLES = 200;   // longer than the slowest insert shift
	localparam int RANDOM_ITEMS  = 375;
	localparam int BLOCK_ITEMS   = 30;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] payload;
	} queue_entry_t;

	typedef struct packed {
		logic               out_valid;
		logic [KEY_W-1:0]   out_key;
		logic [DATA_W-1:0]  out_payload;
		logic               insert_ok;
		logic [COUNT_W-1:0] entry_count;
	} queue_result_t;

	logic clk;
	logic arst_n;

	spq_req_if req_if ();
	spq_res_if res_if ();

	sorted_priority_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if)
	);

	// shadow copy of the queue, kept in ascending key order
	queue_entry_t  held_entries[$];
	// results the block still owes, oldest first
	queue_result_t owed_results[$];

	int error_count;
	int pressure_hold;      // set by a test, consumed by the receiver
	bit send_gaps_on;
	bit recv_stalls_on;

	// run statistics for the summary
	int n_requests, n_inserts, n_refused, n_pops, n_empty_pops, n_flushes, n_unused;
	int peak_count;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// slot where a new key goes: front when empty or not above the head,
	// end when not below the tail, otherwise before the first key not less
	// than it, so equal keys in the middle land ahead of the old ones
	function automatic int unsigned insert_slot(logic [KEY_W-1:0] key);
		int unsigned n;
		int unsigned pos;
		n = held_entries.size();
		if (n == 0 || key <= held_entries[0].key) return 0;
		if (key >= held_entries[n-1].key) return n;
		pos = 1;
		while (pos < n && held_entries[pos].key < key) pos++;
		return pos;
	endfunction

	// applies one accepted request to the shadow queue and returns the result
	// the block must give for it
	function automatic queue_result_t apply_request(logic [1:0] kind, logic [KEY_W-1:0] key,
			logic [DATA_W-1:0] payload);
		queue_result_t r;
		queue_entry_t  e;
		r = '0;
		n_requests++;
		case (kind)
			spq_pkg::REQ_INSERT: begin
				n_inserts++;
				if (held_entries.size() < DEPTH) begin
					e.key     = key;
					e.payload = payload;
					held_entries.insert(insert_slot(key), e);
					r.insert_ok = 1'b1;
				end else begin
					// full queue drops the entry
					n_refused++;
				end
			end
			spq_pkg::REQ_POP: begin
				if (held_entries.size() > 0) begin
					e = held_entries.pop_front();
					r.out_valid   = 1'b1;
					r.out_key     = e.key;
					r.out_payload = e.payload;
					n_pops++;
				end else begin
					n_empty_pops++;
				end
			end
			spq_pkg::REQ_FLUSH: begin
				held_entries.delete();
				n_flushes++;
			end
			default: begin
				n_unused++;
			end
		endcase
		r.entry_count = COUNT_W'(held_entries.size());
		if (held_entries.size() > peak_count) peak_count = held_entries.size();
		return r;
	endfunction

	// keys biased toward ties and the ends of the range
	function automatic logic [KEY_W-1:0] random_key();
		logic [KEY_W-1:0] key;
		case ($urandom_range(0, 3))
			0: key = KEY_W'($urandom_range(0, 7));
			1: key = $urandom_range(0, 1) ? '1 : '0;
			2: key = '1 - KEY_W'($urandom_range(0, 7));
			default: key = KEY_W'($urandom);
		endcase
		return key;
	endfunction

	// offers one request transaction after a random gap and predicts its
	// result once it is accepted; valid stays high so that a following call
	// in the same time step can reuse it without a drop
	task automatic send_request(logic [1:0] kind, logic [KEY_W-1:0] key,
			logic [DATA_W-1:0] payload);
		int unsigned gap;
		gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.req_type      <= kind;
		req_if.entry_key     <= key;
		req_if.entry_payload <= payload;
		do @(posedge clk); while (!req_if.ready);
		owed_results.push_back(apply_request(kind, key, payload));
	endtask

	// random request with the given share of inserts, in percent
	task automatic send_random(int unsigned insert_pct);
		int unsigned roll;
		logic [1:0]  kind;
		roll = $urandom_range(0, 99);
		if (roll < 2)                    kind = spq_pkg::REQ_FLUSH;
		else if (roll < 4)               kind = REQ_UNUSED;
		else if (roll < 4 + insert_pct)  kind = spq_pkg::REQ_INSERT;
		else                             kind = spq_pkg::REQ_POP;
		send_request(kind, random_key(), DATA_W'($urandom));
	endtask

	// stop offering and wait for every owed result
	task automatic drain_results();
		int waited;
		req_if.valid <= 1'b0;
		waited = 0;
		while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (owed_results.size() != 0) begin
			$error("%0d result transactions never arrived", owed_results.size());
			error_count++;
			owed_results.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// receiver: random stall before each result, or one long hold-off when a
	// test asks for it
	initial begin
		int stall;
		res_if.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (pressure_hold > 0) begin
				stall = pressure_hold;
				pressure_hold = 0;
			end else begin
				stall = recv_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
			end
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	// checker: every result transaction against the oldest owed result
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (owed_results.size() == 0) begin
				$error("result transaction with no request outstanding");
				error_count++;
			end else begin
				want = owed_results.pop_front();
				if (res_if.out_valid !== want.out_valid) begin
					$error("out_valid: expected %0h, got %0h", want.out_valid, res_if.out_valid);
					error_count++;
				end
				if (res_if.out_key !== want.out_key) begin
					$error("out_key: expected %0h, got %0h", want.out_key, res_if.out_key);
					error_count++;
				end
				if (res_if.out_payload !== want.out_payload) begin
					$error("out_payload: expected %0h, got %0h", want.out_payload,
						res_if.out_payload);
					error_count++;
				end
				if (res_if.insert_ok !== want.insert_ok) begin
					$error("insert_ok: expected %0h, got %0h", want.insert_ok, res_if.insert_ok);
					error_count++;
				end
				if (res_if.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						res_if.entry_count);
					error_count++;
				end
			end
		end
	end

	// empty-queue requests, tie breaking at head, tail and middle, full
	// drain by pops, flush with entries, unused code
	task automatic test_special_cases();
		int i;
		send_request(spq_pkg::REQ_POP,    16'h0000, 32'h0);
		send_request(REQ_UNUSED,          16'hFFFF, 32'hFFFF_FFFF);
		send_request(spq_pkg::REQ_FLUSH,  16'h0000, 32'h0);
		send_request(spq_pkg::REQ_INSERT, 16'h1234, 32'h0000_0001);
		// equal to head goes in front
		send_request(spq_pkg::REQ_INSERT, 16'h1234, 32'h0000_0002);
		send_request(spq_pkg::REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		// equal to tail goes behind
		send_request(spq_pkg::REQ_INSERT, 16'hFFFF, 32'h0000_0003);
		send_request(spq_pkg::REQ_INSERT, 16'h0000, 32'h0000_0000);
		send_request(spq_pkg::REQ_INSERT, 16'h8000, 32'h0000_0004);
		// equal key in the middle goes ahead of the stored one
		send_request(spq_pkg::REQ_INSERT, 16'h8000, 32'h0000_0005);
		send_request(spq_pkg::REQ_INSERT, 16'h1234, 32'h0000_0006);
		send_request(REQ_UNUSED,          16'hA5A5, 32'h5A5A_A5A5);
		for (i = 0; i < 8; i++)
			send_request(spq_pkg::REQ_POP, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(spq_pkg::REQ_POP,    16'h0000, 32'h0);
		send_request(spq_pkg::REQ_INSERT, 16'hAAAA, 32'h5555_AAAA);
		send_request(spq_pkg::REQ_INSERT, 16'h5555, 32'hAAAA_5555);
		send_request(spq_pkg::REQ_FLUSH,  16'hFFFF, 32'hFFFF_FFFF);
		send_request(spq_pkg::REQ_POP,    16'h0000, 32'h0);
		drain_results();
	endtask

	// fill to DEPTH, refuse more, then work at the full mark
	task automatic test_full_queue();
		int i;
		send_request(spq_pkg::REQ_FLUSH, 16'h0, 32'h0);
		for (i = 0; i < DEPTH; i++)
			send_request(spq_pkg::REQ_INSERT, random_key(), DATA_W'($urandom));
		for (i = 0; i < 3; i++)
			send_request(spq_pkg::REQ_INSERT, random_key(), DATA_W'($urandom));
		send_request(REQ_UNUSED, random_key(), DATA_W'($urandom));
		send_request(spq_pkg::REQ_POP, random_key(), DATA_W'($urandom));
		send_request(spq_pkg::REQ_INSERT, random_key(), DATA_W'($urandom));
		send_request(spq_pkg::REQ_INSERT, random_key(), DATA_W'($urandom));
		for (i = 0; i < 4; i++)
			send_request(spq_pkg::REQ_POP, random_key(), DATA_W'($urandom));
		send_request(spq_pkg::REQ_FLUSH, random_key(), DATA_W'($urandom));
		drain_results();
	endtask

	// receiver holds off for a long stretch while requests keep coming, so
	// the result register and the request port both back up
	task automatic test_backpressure();
		int i;
		send_gaps_on  = 1'b0;
		pressure_hold = HOLD_OFF;
		for (i = 0; i < 24; i++)
			send_random(60);
		send_gaps_on = 1'b1;
		drain_results();
	endtask

	// random traffic in blocks, each with its own insert share and idling
	task automatic test_random_traffic();
		int i;
		int unsigned insert_pct;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % BLOCK_ITEMS == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 85;
					1: insert_pct = 50;
					default: insert_pct = 25;
				endcase
				// some blocks run back to back on one or both sides
				send_gaps_on   = ($urandom_range(0, 3) != 0);
				recv_stalls_on = ($urandom_range(0, 3) != 0);
			end
			send_random(insert_pct);
		end
		send_gaps_on   = 1'b1;
		recv_stalls_on = 1'b1;
		drain_results();
	endtask

	// main sequence
	initial begin
		error_count    = 0;
		pressure_hold  = 0;
		send_gaps_on   = 1'b1;
		recv_stalls_on = 1'b1;
		n_requests = 0; n_inserts = 0; n_refused = 0; n_pops = 0;
		n_empty_pops = 0; n_flushes = 0; n_unused = 0; peak_count = 0;
		arst_n = 1'b0;
		req_if.valid         <= 1'b0;
		req_if.req_type      <= spq_pkg::REQ_POP;
		req_if.entry_key     <= '0;
		req_if.entry_payload <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_full_queue();
		test_backpressure();
		test_random_traffic();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d inserts (%0d refused when full), %0d pops",
			n_requests, n_inserts, n_refused, n_pops + n_empty_pops);
		$display("pops on empty %0d, flushes %0d, unused codes %0d, peak occupancy %0d",
			n_empty_pops, n_flushes, n_unused, peak_count);
		if (error_count == 0) begin
			$display("sorted_priority_queue_tb: clean");
		end else begin
			$display("sorted_priority_queue_tb: errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("sorted_priority_queue_tb: errors");
		$finish;
	end

endmodule

/* files.f */
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_ram.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
tb/sorted_priority_queue_tb.sv
